// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Codes, field widths and color temperature tables for the RGB button dimmer.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int LevelW  = 8;
  localparam int KelvinW = 13;
  localparam int TabN    = 73;
  localparam int IdxW    = 7;
  localparam int QuotW   = 7;

  localparam logic [KelvinW-1:0] KelvinLow  = 13'd800;
  localparam logic [KelvinW-1:0] KelvinHigh = 13'd8000;
  localparam logic [QuotW-1:0]   IdxOffset  = 7'd8;
  localparam logic [IdxW-1:0]    IdxLast    = 7'd72;
  localparam logic [12:0]        RecipHund  = 13'd5243;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_CLICK  = 2'd1,
    ACT_DOUBLE = 2'd2,
    ACT_MULTI  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    BTN_RED   = 2'd0,
    BTN_GREEN = 2'd1,
    BTN_BLUE  = 2'd2,
    BTN_NONE  = 2'd3
  } button_t;

  localparam logic [2:0] CntRestore = 3'd3;
  localparam logic [2:0] CntSave    = 3'd4;
  localparam logic [2:0] CntDefault = 3'd5;

  localparam logic [1:0] CfgDefRed   = 2'd0;
  localparam logic [1:0] CfgDefGreen = 2'd1;
  localparam logic [1:0] CfgDefBlue  = 2'd2;
  localparam logic [1:0] CfgStep     = 2'd3;

  typedef logic [LevelW-1:0] level_t;
  typedef level_t levels_t [3];

  localparam level_t TabRed [TabN] = '{
    255,255,255,255,255,255,255,255,255,255,255,255,
    255,255,255,255,255,255,255,255,255,255,
    255,255,255,255,255,255,255,255,255,255,
    255,255,255,255,255,255,255,255,255,255,
    255,255,255,255,255,255,255,255,255,255,
    255,255,255,255,255,255,255,
    254,249,246,242,239,236,234,231,229,227,226,224,222,221
  };

  localparam level_t TabGreen [TabN] = '{
    45,57,67,77,86,94,101,108,114,120,126,131,
    136,141,146,150,155,159,162,166,170,173,
    177,180,183,186,189,192,195,198,200,203,
    205,208,210,213,215,217,219,221,223,226,
    228,229,231,233,235,237,239,241,242,244,
    246,247,249,251,252,254,255,
    248,246,244,242,240,238,237,236,234,233,232,231,230,229
  };

  localparam level_t TabBlue [TabN] = '{
    0,0,0,0,0,0,0,0,0,0,0,0,
    13,27,39,50,60,70,79,87,95,102,
    109,116,123,129,135,140,146,151,156,161,
    166,170,175,179,183,187,191,195,198,202,
    205,209,212,215,219,222,225,228,231,234,
    236,239,242,244,247,250,252,
    255,255,255,255,255,255,255,255,255,255,255,255,255,255
  };

  // Table row for a temperature: kelvin/100 by reciprocal multiply, minus 8.
  function automatic logic [IdxW-1:0] kelvin_index(input logic [KelvinW-1:0] k);
    logic [25:0]      prod;
    logic [QuotW-1:0] quot;
    logic [QuotW-1:0] diff;
    prod = k * RecipHund;
    quot = prod[25:19];
    diff = quot - IdxOffset;
    if (quot < IdxOffset) begin
      kelvin_index = '0;
    end else if (diff > IdxLast) begin
      kelvin_index = IdxLast;
    end else begin
      kelvin_index = diff;
    end
  endfunction

  function automatic level_t step_level(input level_t lvl, input logic up);
    if (up) begin
      step_level = (lvl == 8'd255) ? lvl : lvl + 8'd1;
    end else begin
      step_level = (lvl == 8'd0) ? lvl : lvl - 8'd1;
    end
  endfunction

endpackage

// ===== rtl/rgb_button_dimmer_with_color_temp_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_button_dimmer_with_color_temp_unit
// Button gesture dimmer for three LED channels with a color temperature mode.
// ----------------------------------------------------------------------------
// An accepted input word is registered in the p_ stage and then in the o_ stage to form its result word.
// Throughput: one word per cycle while the output is not stalled; state updates in the cycle of acceptance.
// Temperature moves are stored as kelvin plus a table flag and resolved
// through the color table both on the next state read and at the output stage.
// Reset (rst, synchronous): levels and presets zero, all directions up,
// 800 K, configuration registers to their defaults, both stages empty.
module rgb_button_dimmer_with_color_temp_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[1:0], button[3:2], click_count[6:4], held_mask[9:7], zero fill
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // red_level[7:0], green_level[15:8], blue_level[23:16],
  // temperature_kelvin[36:24], zero fill
  output logic [39:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  rbd_pkg::level_t             dflt [3];
  logic [7:0]                  kstep;

  rbd_pkg::level_t             lvl [3];
  logic                        tab;
  logic [2:0]                  up;
  logic [rbd_pkg::KelvinW-1:0] kelvin;
  rbd_pkg::level_t             preset [3][3];

  rbd_pkg::level_t             lvl_eff [3];
  rbd_pkg::level_t             lvl_next [3];
  logic                        tab_next;
  logic [2:0]                  up_next;
  logic [rbd_pkg::KelvinW-1:0] kelvin_next;
  rbd_pkg::level_t             row_rd [3];
  logic                        save;

  logic                        p_valid;
  rbd_pkg::level_t             p_lvl [3];
  logic                        p_tab;
  logic [rbd_pkg::KelvinW-1:0] p_kelvin;

  logic                        out_load;
  logic                        accept;
  logic [rbd_pkg::IdxW-1:0]    idx_state;
  logic [rbd_pkg::IdxW-1:0]    idx_out;
  rbd_pkg::level_t             o_lvl [3];
  logic [rbd_pkg::KelvinW-1:0] o_kelvin;

  rbd_pkg::action_t            action;
  rbd_pkg::button_t            button;
  logic [2:0]                  click_count;
  logic [2:0]                  held_mask;

  logic [rbd_pkg::KelvinW:0]   k_sum;
  logic [rbd_pkg::KelvinW:0]   k_floor;

  assign action      = rbd_pkg::action_t'(s_tdata[1:0]);
  assign button      = rbd_pkg::button_t'(s_tdata[3:2]);
  assign click_count = s_tdata[6:4];
  assign held_mask   = s_tdata[9:7];

  assign cfg_ready = 1'b1;
  assign out_load  = !m_tvalid || m_tready;
  assign s_tready  = !p_valid || out_load;
  assign accept    = s_tvalid && s_tready;

  assign idx_state = rbd_pkg::kelvin_index(kelvin);
  assign idx_out   = rbd_pkg::kelvin_index(p_kelvin);

  assign k_sum   = {1'b0, kelvin} + {6'd0, kstep};
  assign k_floor = {1'b0, rbd_pkg::KelvinLow} + {6'd0, kstep};

  always_comb begin
    lvl_eff[0] = tab ? rbd_pkg::TabRed[idx_state]   : lvl[0];
    lvl_eff[1] = tab ? rbd_pkg::TabGreen[idx_state] : lvl[1];
    lvl_eff[2] = tab ? rbd_pkg::TabBlue[idx_state]  : lvl[2];
  end

  always_comb begin
    unique case (button)
      rbd_pkg::BTN_GREEN: row_rd = preset[1];
      rbd_pkg::BTN_BLUE:  row_rd = preset[2];
      default:            row_rd = preset[0];
    endcase
  end

  always_comb begin
    lvl_next    = lvl_eff;
    tab_next    = 1'b0;
    up_next     = up;
    kelvin_next = kelvin;
    save        = 1'b0;
    if (button != rbd_pkg::BTN_NONE) begin
      unique case (action)
        rbd_pkg::ACT_TICK: begin
          if (button == rbd_pkg::BTN_RED) begin
            priority if (held_mask[2]) begin
              tab_next = 1'b1;
              kelvin_next = (k_sum > {1'b0, rbd_pkg::KelvinHigh}) ?
                            rbd_pkg::KelvinHigh : k_sum[rbd_pkg::KelvinW-1:0];
            end else if (held_mask[1]) begin
              tab_next = 1'b1;
              kelvin_next = ({1'b0, kelvin} >= k_floor) ?
                            kelvin - {5'd0, kstep} : rbd_pkg::KelvinLow;
            end else begin
              lvl_next[0] = rbd_pkg::step_level(lvl_eff[0], up[0]);
            end
          end else if (!held_mask[0]) begin
            lvl_next[button] = rbd_pkg::step_level(lvl_eff[button], up[button]);
          end
        end
        rbd_pkg::ACT_CLICK: begin
          up_next[button] = !up[button];
        end
        rbd_pkg::ACT_DOUBLE: begin
          lvl_next[button] = '0;
        end
        default: begin
          if (click_count == rbd_pkg::CntRestore) begin
            lvl_next = row_rd;
          end else if (click_count == rbd_pkg::CntSave) begin
            save = 1'b1;
          end else if (click_count == rbd_pkg::CntDefault) begin
            lvl_next[0] = dflt[button];
            lvl_next[1] = dflt[button];
            lvl_next[2] = dflt[button];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dflt[0] <= 8'd255;
      dflt[1] <= 8'd150;
      dflt[2] <= 8'd50;
      kstep   <= 8'd30;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rbd_pkg::CfgDefRed:   dflt[0] <= cfg_data;
        rbd_pkg::CfgDefGreen: dflt[1] <= cfg_data;
        rbd_pkg::CfgDefBlue:  dflt[2] <= cfg_data;
        default:              kstep   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        lvl[i] <= '0;
        for (int j = 0; j < 3; j++) begin
          preset[i][j] <= '0;
        end
      end
      tab    <= 1'b0;
      up     <= 3'b111;
      kelvin <= rbd_pkg::KelvinLow;
    end else if (accept) begin
      lvl    <= lvl_next;
      tab    <= tab_next;
      up     <= up_next;
      kelvin <= kelvin_next;
      for (int r = 0; r < 3; r++) begin
        if (save && (button == rbd_pkg::button_t'(r))) begin
          preset[r] <= lvl_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        p_valid <= accept;
      end
      if (out_load) begin
        m_tvalid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_lvl    <= lvl_next;
      p_tab    <= tab_next;
      p_kelvin <= kelvin_next;
    end
    if (out_load && p_valid) begin
      o_lvl[0] <= p_tab ? rbd_pkg::TabRed[idx_out]   : p_lvl[0];
      o_lvl[1] <= p_tab ? rbd_pkg::TabGreen[idx_out] : p_lvl[1];
      o_lvl[2] <= p_tab ? rbd_pkg::TabBlue[idx_out]  : p_lvl[2];
      o_kelvin <= p_kelvin;
    end
  end

  assign m_tdata = {3'd0, o_kelvin, o_lvl[2], o_lvl[1], o_lvl[0]};

endmodule
